/* hw/rtl/bfps_pkg.sv */
// Shared types and constants for the byte FIFO with peek and skip.
// No dependencies; used by every module of the block.
`default_nettype none

package bfps_pkg;

    localparam int unsigned DEPTH_DEF   = 4096;
    localparam int unsigned MAX_RUN_DEF = 64;
    localparam int unsigned Q_DEPTH     = 2;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned LEN_W  = 7;
    localparam int unsigned CNT_W  = 7;

    typedef enum logic [1:0] {
        OP_PUT  = 2'd0,
        OP_GET  = 2'd1,
        OP_PEEK = 2'd2,
        OP_SKIP = 2'd3
    } bfps_op_t;

    typedef struct packed {
        bfps_op_t            op;
        logic [BYTE_W-1:0]   data;
        logic [LEN_W-1:0]    len;
    } bfps_item_t;

endpackage

`default_nettype wire

/* hw/rtl/byte_fifo_peek_skip.sv */
// Byte FIFO with put, get, peek and skip over a power-of-two ring memory.
// Depends on bfps_pkg, bfps_front, bfps_queue and bfps_back.
//
// Commands are taken when start is high and busy is low; busy rises only when the
// two-entry command queue is full. Results appear on done for one cycle each and
// cannot be held off. The back end takes a put, skip or status-only command in its
// idle state alone; a get or peek that delivers bytes then passes to its run state,
// which delivers one byte per cycle from the ring memory read port. With the queue
// empty and the back end idle, a taken command goes through the queue entry and then
// the result registers; the first byte of a get or peek also goes through the run state.
`default_nettype none

module byte_fifo_peek_skip #(
    parameter int unsigned DEPTH   = bfps_pkg::DEPTH_DEF,
    parameter int unsigned MAX_RUN = bfps_pkg::MAX_RUN_DEF,
    parameter int unsigned FILL_W  = $clog2(DEPTH) + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   func,
    input  wire logic [bfps_pkg::BYTE_W-1:0]  put_byte,
    input  wire logic [bfps_pkg::LEN_W-1:0]   length,
    output logic                              done,
    output logic [bfps_pkg::BYTE_W-1:0]       out_byte,
    output logic                              byte_valid,
    output logic                              ok,
    output logic [bfps_pkg::CNT_W-1:0]        count,
    output logic                              last,
    output logic [FILL_W-1:0]                 fill_level
);

    logic                  q_full;
    logic                  q_empty;
    logic                  push;
    logic                  pop;
    bfps_pkg::bfps_item_t  item;
    bfps_pkg::bfps_item_t  head;

    bfps_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .start    (start),
        .func     (func),
        .put_byte (put_byte),
        .length   (length),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .item     (item)
    );

    bfps_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (head)
    );

    bfps_back #(
        .DEPTH (DEPTH),
        .AW    (FILL_W - 1),
        .IW    (FILL_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .head       (head),
        .pop        (pop),
        .done       (done),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .ok         (ok),
        .count      (count),
        .last       (last),
        .fill_level (fill_level)
    );

endmodule

`default_nettype wire

/* hw/rtl/bfps_front.sv */
// Front end: takes command transactions, decodes the operation and clamps the length.
// Depends on bfps_pkg.
`default_nettype none

module bfps_front #(
    parameter int unsigned MAX_RUN = bfps_pkg::MAX_RUN_DEF
) (
    input  wire logic                         start,
    input  wire logic [1:0]                   func,
    input  wire logic [bfps_pkg::BYTE_W-1:0]  put_byte,
    input  wire logic [bfps_pkg::LEN_W-1:0]   length,
    input  wire logic                         q_full,
    output logic                              busy,
    output logic                              push,
    output bfps_pkg::bfps_item_t              item
);

    localparam logic [bfps_pkg::LEN_W-1:0] RUN_MAX = bfps_pkg::LEN_W'(MAX_RUN);

    always_comb
    begin
        busy      = q_full;
        push      = start && !q_full;
        item.op   = bfps_pkg::bfps_op_t'(func);
        item.data = put_byte;
        item.len  = (length > RUN_MAX) ? RUN_MAX : length;
    end

endmodule

`default_nettype wire

/* hw/rtl/bfps_queue.sv */
// Short command queue between front end and back end.
// Depends on bfps_pkg.
`default_nettype none

module bfps_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire bfps_pkg::bfps_item_t  push_item,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       empty,
    output bfps_pkg::bfps_item_t       head
);

    localparam int unsigned QAW = $clog2(bfps_pkg::Q_DEPTH);
    localparam int unsigned QCW = $clog2(bfps_pkg::Q_DEPTH + 1);
    localparam logic [QAW-1:0] PTR_LAST = QAW'(bfps_pkg::Q_DEPTH - 1);
    localparam logic [QCW-1:0] CNT_FULL = QCW'(bfps_pkg::Q_DEPTH);

    bfps_pkg::bfps_item_t entries [bfps_pkg::Q_DEPTH];
    logic [QAW-1:0] wp_reg, wp_next;
    logic [QAW-1:0] rp_reg, rp_next;
    logic [QCW-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        full     = (cnt_reg == CNT_FULL);
        empty    = (cnt_reg == '0);
        head     = entries[rp_reg];
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wp_next = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
        end
        if (pop)
        begin
            rp_next = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wp_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/bfps_back.sv */
// Back end: owns the ring memory and indices, executes queued commands, drives results.
// Depends on bfps_pkg.
`default_nettype none

module bfps_back #(
    parameter int unsigned DEPTH = bfps_pkg::DEPTH_DEF,
    parameter int unsigned AW    = $clog2(DEPTH),
    parameter int unsigned IW    = AW + 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  wire bfps_pkg::bfps_item_t         head,
    output logic                              pop,
    output logic                              done,
    output logic [bfps_pkg::BYTE_W-1:0]       out_byte,
    output logic                              byte_valid,
    output logic                              ok,
    output logic [bfps_pkg::CNT_W-1:0]        count,
    output logic                              last,
    output logic [IW-1:0]                     fill_level
);

    localparam int unsigned CW = (IW > bfps_pkg::LEN_W) ? IW : bfps_pkg::LEN_W;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    logic [bfps_pkg::BYTE_W-1:0] ring_mem [DEPTH];
    logic [bfps_pkg::BYTE_W-1:0] rdata_reg;

    state_t                      state_reg, state_next;
    logic [IW-1:0]               wr_idx_reg, wr_idx_next;
    logic [IW-1:0]               rd_idx_reg, rd_idx_next;
    logic [AW-1:0]               addr_reg, addr_next;
    logic [bfps_pkg::CNT_W-1:0]  left_reg, left_next;
    logic                        done_reg, done_next;
    logic                        bv_reg, bv_next;
    logic                        ok_reg, ok_next;
    logic [bfps_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic                        last_reg, last_next;
    logic [IW-1:0]               fill_reg, fill_next;

    logic [IW-1:0]               fill;
    logic [CW-1:0]               fill_c;
    logic [CW-1:0]               len_c;
    logic [CW-1:0]               n_c;
    logic                        enough;
    logic                        wr_en;

    always_comb
    begin
        fill   = wr_idx_reg - rd_idx_reg;
        fill_c = CW'(fill);
        len_c  = CW'(head.len);
        enough = (fill_c >= len_c);
        n_c    = '0;
        wr_en  = 1'b0;
        pop    = 1'b0;

        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        addr_next   = addr_reg;
        left_next   = left_reg;
        done_next   = 1'b0;
        bv_next     = 1'b0;
        ok_next     = ok_reg;
        cnt_next    = cnt_reg;
        last_next   = 1'b0;
        fill_next   = fill_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    case (head.op)
                        bfps_pkg::OP_PUT:
                        begin
                            if (!fill[AW])
                            begin
                                wr_en       = 1'b1;
                                wr_idx_next = wr_idx_reg + 1'b1;
                                n_c         = CW'(1);
                            end
                        end
                        bfps_pkg::OP_SKIP:
                        begin
                            if (enough)
                            begin
                                n_c = len_c;
                            end
                            rd_idx_next = rd_idx_reg + n_c[IW-1:0];
                        end
                        bfps_pkg::OP_GET:
                        begin
                            n_c         = (len_c < fill_c) ? len_c : fill_c;
                            rd_idx_next = rd_idx_reg + n_c[IW-1:0];
                        end
                        bfps_pkg::OP_PEEK:
                        begin
                            n_c = enough ? len_c : '0;
                        end
                        default:
                        begin
                            n_c = '0;
                        end
                    endcase
                    cnt_next  = n_c[bfps_pkg::CNT_W-1:0];
                    ok_next   = (n_c != '0);
                    fill_next = wr_idx_next - rd_idx_next;
                    if ((head.op == bfps_pkg::OP_GET || head.op == bfps_pkg::OP_PEEK)
                        && n_c != '0)
                    begin
                        addr_next  = rd_idx_reg[AW-1:0];
                        left_next  = n_c[bfps_pkg::CNT_W-1:0];
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        done_next = 1'b1;
                        last_next = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                done_next = 1'b1;
                bv_next   = 1'b1;
                last_next = (left_reg == bfps_pkg::CNT_W'(1));
                addr_next = addr_reg + 1'b1;
                left_next = left_reg - 1'b1;
                if (left_reg == bfps_pkg::CNT_W'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            addr_reg   <= '0;
            left_reg   <= '0;
            done_reg   <= 1'b0;
            bv_reg     <= 1'b0;
            ok_reg     <= 1'b0;
            cnt_reg    <= '0;
            last_reg   <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            addr_reg   <= addr_next;
            left_reg   <= left_next;
            done_reg   <= done_next;
            bv_reg     <= bv_next;
            ok_reg     <= ok_next;
            cnt_reg    <= cnt_next;
            last_reg   <= last_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_idx_reg[AW-1:0]] <= head.data;
        end
        if (state_reg == ST_RUN)
        begin
            rdata_reg <= ring_mem[addr_reg];
        end
    end

    always_comb
    begin
        done       = done_reg;
        byte_valid = bv_reg;
        out_byte   = bv_reg ? rdata_reg : '0;
        ok         = ok_reg;
        count      = cnt_reg;
        last       = last_reg;
        fill_level = fill_reg;
    end

endmodule

`default_nettype wire
